@@ rtl/ttm_pkg.sv @@
package ttm_pkg;

	localparam int IDX_W      = 9;
	localparam int ENTRIES    = 512;
	localparam int PA_W       = 48;
	localparam int PFN_W      = 36;
	localparam int DESC_W     = 64;
	localparam int UXN_POS    = 54;
	localparam int AF_POS     = 10;
	localparam int SH_POS     = 8;
	localparam int AP_POS     = 6;
	localparam int ATTR_POS   = 2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	localparam logic [1:0] DESC_BLOCK = 2'b01;
	localparam logic [1:0] DESC_TABLE = 2'b11;

	localparam logic [1:0] KIND_BLOCK  = 2'd0;
	localparam logic [1:0] KIND_PAGE   = 2'd1;
	localparam logic [1:0] KIND_UNMAP  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] ST_WRITTEN   = 2'd0;
	localparam logic [1:0] ST_SKIPPED   = 2'd1;
	localparam logic [1:0] ST_NONE      = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam logic [1:0] PL_EL0    = 2'd0;
	localparam logic [1:0] PL_EL1    = 2'd1;
	localparam logic [1:0] PL_SHARED = 2'd2;
	localparam logic [1:0] PL_OTHER  = 2'd3;

	typedef struct packed {
		logic [1:0]      kind;
		logic [PA_W-1:0] virt_addr;
		logic [PA_W-1:0] phys_addr;
		logic [2:0]      attr_sel;
		logic [1:0]      privilege_level;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic       flush_request;
	} out_word_t;

	typedef enum logic [2:0] {
		S_ZERO_ROOT,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_CLEAR,
		S_DONE
	} state_t;

	function automatic logic [IDX_W-1:0] va_index(logic [PA_W-1:0] va, logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	function automatic logic [DESC_W-1:0] block_desc(logic [PA_W-1:0] pa, logic [2:0] attr);
		logic [DESC_W-1:0] d;
		d = '0;
		d[47:12] = pa[47:12];
		d[UXN_POS] = 1'b1;
		d[AF_POS] = 1'b1;
		d[SH_POS +: 2] = 2'b11;
		d[ATTR_POS +: 3] = attr;
		d[1:0] = DESC_BLOCK;
		return d;
	endfunction

	function automatic logic [DESC_W-1:0] page_desc(logic [PA_W-1:0] pa, logic [2:0] attr,
			logic [1:0] pl);
		logic [DESC_W-1:0] d;
		logic [1:0]        ap;
		logic              uxn;
		uxn = 1'b0;
		unique case (pl)
			PL_EL0:    ap = 2'b01;
			PL_EL1: begin
				ap = 2'b00;
				uxn = 1'b1;
			end
			PL_SHARED: ap = 2'b10;
			default:   ap = 2'b00;
		endcase
		d = '0;
		d[47:12] = pa[47:12];
		d[UXN_POS] = uxn;
		d[AF_POS] = 1'b1;
		d[SH_POS +: 2] = 2'b01;
		d[AP_POS +: 2] = ap;
		d[ATTR_POS +: 3] = attr;
		d[1:0] = DESC_TABLE;
		return d;
	endfunction

	function automatic logic [DESC_W-1:0] table_desc(logic [PFN_W-1:0] pfn);
		logic [DESC_W-1:0] d;
		d = '0;
		d[47:12] = pfn;
		d[1:0] = DESC_TABLE;
		return d;
	endfunction

endpackage

@@ rtl/ttm_mem.sv @@
module ttm_mem #(
	parameter int NUM_TABLES = 64
) (
	input  logic                                        clk,
	input  logic                                        re,
	input  logic                                        we,
	input  logic [$clog2(NUM_TABLES)+ttm_pkg::IDX_W-1:0] addr,
	input  logic [ttm_pkg::DESC_W-1:0]                  wdata,
	output logic [ttm_pkg::DESC_W-1:0]                  rdata
);
	import ttm_pkg::*;

	localparam int DEPTH = NUM_TABLES * ENTRIES;

	logic [DESC_W-1:0] store_q [DEPTH];
	logic [DESC_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= store_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ttm_ctrl.sv @@
module ttm_ctrl #(
	parameter int NUM_TABLES = 64
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  ttm_pkg::in_word_t                           in_data,
	input  logic [ttm_pkg::PFN_W-1:0]                   pool_pfn,
	output logic                                        res_valid,
	input  logic                                        res_ready,
	output ttm_pkg::out_word_t                          res_word,
	output logic                                        mem_re,
	output logic                                        mem_we,
	output logic [$clog2(NUM_TABLES)+ttm_pkg::IDX_W-1:0] mem_addr,
	output logic [ttm_pkg::DESC_W-1:0]                  mem_wdata,
	input  logic [ttm_pkg::DESC_W-1:0]                  mem_rdata
);
	import ttm_pkg::*;

	localparam int TBL_W = $clog2(NUM_TABLES);
	localparam int CNT_W = $clog2(NUM_TABLES + 1);

	state_t           state_q, state_d;
	in_word_t         item_q;
	logic [1:0]       lvl_q, lvl_d;
	logic [TBL_W-1:0] tbl_q, tbl_d;
	logic [CNT_W-1:0] nf_q, nf_d;
	logic [IDX_W-1:0] clr_q, clr_d;
	logic [1:0]       status_q, status_d;
	logic             flush_q, flush_d;

	logic             accept;
	logic             ent_valid, ent_block, in_pool, pool_full, is_unmap, descend;
	logic [PFN_W-1:0] off, nf_ext;
	logic [TBL_W+IDX_W-1:0] cur_addr;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign ent_valid = mem_rdata[0];
	assign ent_block = (mem_rdata[1:0] == DESC_BLOCK);
	assign nf_ext    = PFN_W'(nf_q);
	assign off       = mem_rdata[47:12] - pool_pfn;
	assign in_pool   = (off < nf_ext);
	assign pool_full = (nf_q == CNT_W'(NUM_TABLES));
	assign is_unmap  = (item_q.kind == KIND_UNMAP);
	assign cur_addr  = {tbl_q, va_index(item_q.virt_addr, lvl_q)};

	assign res_valid              = (state_q == S_DONE);
	assign res_word.status        = status_q;
	assign res_word.flush_request = flush_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_ZERO_ROOT;
			lvl_q    <= '0;
			tbl_q    <= '0;
			nf_q     <= CNT_W'(1);
			clr_q    <= '0;
			status_q <= ST_NONE;
			flush_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			lvl_q    <= lvl_d;
			tbl_q    <= tbl_d;
			nf_q     <= nf_d;
			clr_q    <= clr_d;
			status_q <= status_d;
			flush_q  <= flush_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	always_comb begin
		state_d   = state_q;
		lvl_d     = lvl_q;
		tbl_d     = tbl_q;
		nf_d      = nf_q;
		clr_d     = clr_q;
		status_d  = status_q;
		flush_d   = flush_q;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = cur_addr;
		mem_wdata = '0;
		descend   = 1'b0;
		unique case (state_q)
			S_ZERO_ROOT: begin
				mem_we   = 1'b1;
				mem_addr = {tbl_q, clr_q};
				clr_d    = clr_q + IDX_W'(1);
				if (clr_q == IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					lvl_d   = '0;
					tbl_d   = '0;
					flush_d = 1'b0;
					if (in_data.kind == KIND_UNUSED) begin
						status_d = ST_NONE;
						state_d  = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				mem_re  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				unique case (lvl_q)
					2'd2: begin
						case (item_q.kind)
							KIND_BLOCK: begin
								mem_we    = 1'b1;
								mem_wdata = block_desc(item_q.phys_addr, item_q.attr_sel);
								status_d  = ST_WRITTEN;
								state_d   = S_DONE;
							end
							KIND_PAGE: begin
								if (ent_valid && ent_block) begin
									status_d = ST_SKIPPED;
									state_d  = S_DONE;
								end else begin
									descend = 1'b1;
								end
							end
							default: begin
								if (!ent_valid) begin
									status_d = ST_NONE;
									state_d  = S_DONE;
								end else if (ent_block) begin
									mem_we   = 1'b1;
									status_d = ST_WRITTEN;
									state_d  = S_DONE;
								end else begin
									descend = 1'b1;
								end
							end
						endcase
					end
					2'd3: begin
						if (is_unmap) begin
							if (ent_valid) begin
								mem_we   = 1'b1;
								status_d = ST_WRITTEN;
								flush_d  = 1'b1;
							end else begin
								status_d = ST_NONE;
							end
						end else begin
							if (ent_valid) begin
								status_d = ST_SKIPPED;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = page_desc(item_q.phys_addr, item_q.attr_sel,
									item_q.privilege_level);
								status_d  = ST_WRITTEN;
							end
						end
						state_d = S_DONE;
					end
					default: descend = 1'b1;
				endcase
				if (descend) begin
					if (ent_valid) begin
						if (in_pool) begin
							tbl_d   = off[TBL_W-1:0];
							lvl_d   = lvl_q + 2'd1;
							state_d = S_READ;
						end else begin
							status_d = is_unmap ? ST_NONE : ST_EXHAUSTED;
							state_d  = S_DONE;
						end
					end else if (is_unmap) begin
						status_d = ST_NONE;
						state_d  = S_DONE;
					end else if (pool_full) begin
						status_d = ST_EXHAUSTED;
						state_d  = S_DONE;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = table_desc(pool_pfn + nf_ext);
						tbl_d     = nf_q[TBL_W-1:0];
						nf_d      = nf_q + CNT_W'(1);
						lvl_d     = lvl_q + 2'd1;
						clr_d     = '0;
						state_d   = S_CLEAR;
					end
				end
			end
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = {tbl_q, clr_q};
				clr_d    = clr_q + IDX_W'(1);
				if (clr_q == IDX_LAST) begin
					state_d = S_READ;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("read and write issued together");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= CNT_W'(NUM_TABLES) && nf_q != '0)
		else $error("table counter out of range");

	a_pool_bump: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q != $past(nf_q) |-> nf_q == $past(nf_q) + CNT_W'(1))
		else $error("table counter moved by other than one");

	a_flush_written: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.flush_request |-> res_word.status == ST_WRITTEN
			&& is_unmap)
		else $error("flush without a page unmap");

	a_clear_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR && clr_q == IDX_LAST |=> state_q == S_READ && clr_q == '0)
		else $error("table clear did not finish into a read");

endmodule

@@ rtl/translation_table_map_engine.sv @@
// Maps 2 MB blocks and 4 KB pages into 4-level, 4 KB-granule translation
// tables kept in an on-chip table store of NUM_TABLES tables of 512
// descriptors, and unmaps them; one status word comes back per input word.
// After reset the root table is cleared, while in_stall stays high (cfg
// writes are taken at any time). An item is accepted, reads each table
// level from the single-port store in turn and then presents its result;
// a walk covers one to four levels, and the unused kind reads no table.
// Each new table taken from the pool is zeroed, one descriptor per cycle.
// One item is in flight at a time; the next is taken while a finished
// result waits in the output register.
module translation_table_map_engine #(
	parameter int NUM_TABLES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ttm_pkg::PA_W-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  ttm_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ttm_pkg::out_word_t           out_data
);
	import ttm_pkg::*;

	localparam int ADDR_W = $clog2(NUM_TABLES) + IDX_W;

	logic [PA_W-1:0]   pool_base_q;
	logic              out_valid_q;
	out_word_t         out_data_q;
	logic              res_valid, res_ready;
	out_word_t         res_word;
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [DESC_W-1:0] mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_base_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_word;
		end
	end

	ttm_ctrl #(
		.NUM_TABLES(NUM_TABLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.pool_pfn (pool_base_q[47:12]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word (res_word),
		.mem_re   (mem_re),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	ttm_mem #(
		.NUM_TABLES(NUM_TABLES)
	) u_mem (
		.clk  (clk),
		.re   (mem_re),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule

@@ test/table_walk_checker.sv @@
module table_walk_checker #(
	parameter int NUM_TABLES = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [ttm_pkg::PA_W-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  ttm_pkg::in_word_t        in_data,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  ttm_pkg::out_word_t       out_data,
	output int                       fail_count,
	output int                       backlog
);
	import ttm_pkg::*;

	typedef enum logic [1:0] {W_OK, W_MISSING, W_STRAY, W_FULL} walk_t;

	logic [DESC_W-1:0] tbl [NUM_TABLES*ENTRIES];
	int unsigned       tables_taken;
	logic [PA_W-1:0]   pool_base;
	out_word_t         pending_status [$];
	int                result_no;

	function automatic logic [IDX_W-1:0] level_idx(logic [PA_W-1:0] va, int lvl);
		return va[47 - 9*lvl -: 9];
	endfunction

	// follow the descriptor at parent/ent, or take and link a fresh table
	function automatic walk_t descend(int parent, logic [IDX_W-1:0] ent, bit create,
			output int child);
		logic [DESC_W-1:0] d;
		logic [PA_W-1:0]   base;
		logic [PA_W-1:0]   off;
		int                t;
		d = tbl[parent*ENTRIES + ent];
		base = {pool_base[47:12], 12'h000};
		child = 0;
		if (d[0]) begin
			off = {d[47:12], 12'h000} - base;
			if (off[47:12] >= 36'(tables_taken))
				return W_STRAY;
			child = int'(off[47:12]);
			return W_OK;
		end
		if (!create)
			return W_MISSING;
		if (tables_taken >= NUM_TABLES)
			return W_FULL;
		t = int'(tables_taken);
		tables_taken++;
		for (int i = 0; i < ENTRIES; i++)
			tbl[t*ENTRIES + i] = '0;
		off = base + (PA_W'(t) << 12);
		tbl[parent*ENTRIES + ent] = {16'h0, off[47:12], 10'h0, DESC_TABLE};
		child = t;
		return W_OK;
	endfunction

	function automatic walk_t walk_to_l2(logic [PA_W-1:0] va, bit create, output int l2);
		int    l1;
		walk_t s;
		l2 = 0;
		s = descend(0, level_idx(va, 0), create, l1);
		if (s != W_OK)
			return s;
		return descend(l1, level_idx(va, 1), create, l2);
	endfunction

	function automatic out_word_t update_tables(in_word_t w);
		logic [PA_W-1:0]  va;
		logic [IDX_W-1:0] i2;
		logic [IDX_W-1:0] i3;
		int               l2;
		int               l3;
		int               a;
		logic [1:0]       ap;
		logic             uxn;
		va = w.virt_addr;
		i2 = level_idx(va, 2);
		i3 = level_idx(va, 3);
		if (w.kind == KIND_BLOCK) begin
			if (walk_to_l2(va, 1'b1, l2) != W_OK)
				return {ST_EXHAUSTED, 1'b0};
			tbl[l2*ENTRIES + i2] = {9'd0, 1'b1, 6'd0, w.phys_addr[47:12], 1'b0, 1'b1, 2'b11,
				3'b000, w.attr_sel, DESC_BLOCK};
			return {ST_WRITTEN, 1'b0};
		end
		if (w.kind == KIND_PAGE) begin
			if (walk_to_l2(va, 1'b1, l2) != W_OK)
				return {ST_EXHAUSTED, 1'b0};
			if (tbl[l2*ENTRIES + i2][1:0] == DESC_BLOCK)
				return {ST_SKIPPED, 1'b0};
			if (descend(l2, i2, 1'b1, l3) != W_OK)
				return {ST_EXHAUSTED, 1'b0};
			a = l3*ENTRIES + i3;
			if (tbl[a][0])
				return {ST_SKIPPED, 1'b0};
			uxn = (w.privilege_level == PL_EL1);
			case (w.privilege_level)
				PL_EL0:    ap = 2'b01;
				PL_SHARED: ap = 2'b10;
				default:   ap = 2'b00;
			endcase
			tbl[a] = {9'd0, uxn, 6'd0, w.phys_addr[47:12], 1'b0, 1'b1, 2'b01, ap, 1'b0,
				w.attr_sel, DESC_TABLE};
			return {ST_WRITTEN, 1'b0};
		end
		if (w.kind == KIND_UNMAP) begin
			if (walk_to_l2(va, 1'b0, l2) != W_OK)
				return {ST_NONE, 1'b0};
			a = l2*ENTRIES + i2;
			if (!tbl[a][0])
				return {ST_NONE, 1'b0};
			if (tbl[a][1:0] == DESC_BLOCK) begin
				tbl[a] = '0;
				return {ST_WRITTEN, 1'b0};
			end
			if (descend(l2, i2, 1'b0, l3) != W_OK)
				return {ST_NONE, 1'b0};
			a = l3*ENTRIES + i3;
			if (!tbl[a][0])
				return {ST_NONE, 1'b0};
			tbl[a] = '0;
			return {ST_WRITTEN, 1'b1};
		end
		return {ST_NONE, 1'b0};
	endfunction

	function automatic void note(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_TABLES*ENTRIES; i++)
				tbl[i] = '0;
			tables_taken = 1;
			pool_base = '0;
			pending_status.delete();
			fail_count = 0;
			result_no = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				pool_base = cfg_data;
			// result side first: a word accepted on this edge cannot answer itself
			if (out_valid && !out_stall) begin
				result_no++;
				if (pending_status.size() == 0) begin
					note($sformatf("result %0d: none expected, got status %0d flush %0d",
						result_no, out_data.status, out_data.flush_request));
				end else begin
					want = pending_status.pop_front();
					if (out_data.status !== want.status)
						note($sformatf("result %0d: status expected %0d got %0d",
							result_no, want.status, out_data.status));
					if (out_data.flush_request !== want.flush_request)
						note($sformatf("result %0d: flush_request expected %0d got %0d",
							result_no, want.flush_request, out_data.flush_request));
				end
			end
			if (in_valid && !in_stall)
				pending_status.push_back(update_tables(in_data));
		end
		backlog = pending_status.size();
	end

endmodule

@@ test/testbench.sv @@
module testbench;
	import ttm_pkg::*;

	localparam int NUM_TABLES = 64;

	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [PA_W-1:0] cfg_data;
	logic            in_valid;
	logic            in_stall;
	in_word_t        in_data;
	logic            out_valid;
	logic            out_stall;
	out_word_t       out_data;
	int              fail_count;
	int              backlog;
	int              burst_left;
	bit              hold_now;
	bit              hold_done;

	// small index sets so most walks land on tables that already exist
	logic [IDX_W-1:0] lv0 [2] = '{9'd0, 9'd511};
	logic [IDX_W-1:0] lv1 [2] = '{9'd0, 9'd511};
	logic [IDX_W-1:0] lv2 [3] = '{9'd0, 9'd511, 9'd0};
	logic [IDX_W-1:0] lv3 [4] = '{9'd0, 9'd511, 9'd0, 9'd0};

	translation_table_map_engine #(.NUM_TABLES(NUM_TABLES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	table_walk_checker #(.NUM_TABLES(NUM_TABLES)) walk_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [PA_W-1:0] va_at(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
			logic [IDX_W-1:0] c, logic [IDX_W-1:0] d);
		return {a, b, c, d, 12'h000};
	endfunction

	function automatic in_word_t rand_word();
		in_word_t    w;
		int unsigned r;
		r = $urandom_range(0, 19);
		w.kind = r < 3 ? KIND_BLOCK : r < 12 ? KIND_PAGE : r < 19 ? KIND_UNMAP : KIND_UNUSED;
		if ($urandom_range(0, 15) == 0)
			w.virt_addr = {16'($urandom), $urandom};
		else
			w.virt_addr = {lv0[$urandom_range(0, 1)], lv1[$urandom_range(0, 1)],
				lv2[$urandom_range(0, 2)], lv3[$urandom_range(0, 3)], 12'($urandom)};
		w.phys_addr = {16'($urandom), $urandom};
		w.attr_sel = 3'($urandom);
		w.privilege_level = 2'($urandom);
		return w;
	endfunction

	task automatic send(in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic put(logic [1:0] k, logic [PA_W-1:0] va, logic [PA_W-1:0] pa,
			logic [2:0] attr, logic [1:0] pl);
		in_word_t w;
		w.kind = k;
		w.virt_addr = va;
		w.phys_addr = pa;
		w.attr_sel = attr;
		w.privilege_level = pl;
		send(w);
	endtask

	task automatic random_run(int n, bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == n / 3)
				hold_now = 1'b1;
			send(rand_word());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic write_base(logic [PA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stall patterns, plus one long hold-off on request
	initial begin
		int unsigned mode;
		int unsigned len;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_now && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(5, 60);
				repeat (len) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 1) == 0);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		hold_now = 1'b0;
		burst_left = 0;
		lv2[2] = 9'($urandom_range(1, 510));
		lv3[2] = 9'($urandom_range(1, 510));
		lv3[3] = 9'($urandom_range(1, 510));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		write_base('1);
		put(KIND_UNMAP,  '0, '0, 3'd0, PL_EL0);
		put(KIND_UNUSED, '1, '1, 3'd7, PL_OTHER);
		put(KIND_BLOCK,  va_at(0, 0, 0, 0), '1, 3'd7, PL_EL0);
		put(KIND_PAGE,   va_at(0, 0, 0, 5), '1, 3'd3, PL_EL0);
		put(KIND_UNMAP,  va_at(0, 0, 0, 9), '0, 3'd0, PL_EL0);
		put(KIND_PAGE,   va_at(0, 0, 0, 0), '0, 3'd0, PL_EL0);
		put(KIND_PAGE,   va_at(0, 0, 0, 511), '1, 3'd7, PL_EL1);
		put(KIND_PAGE,   va_at(0, 0, 0, 1), {16'($urandom), $urandom}, 3'd5, PL_SHARED);
		put(KIND_PAGE,   va_at(0, 0, 0, 2), {16'($urandom), $urandom}, 3'd2, PL_OTHER);
		put(KIND_PAGE,   va_at(0, 0, 0, 0), '1, 3'd1, PL_EL1);
		put(KIND_UNMAP,  va_at(0, 0, 0, 511), '0, 3'd0, PL_EL0);
		put(KIND_UNMAP,  va_at(0, 0, 0, 511), '0, 3'd0, PL_EL0);
		put(KIND_UNMAP,  va_at(0, 0, 7, 0), '0, 3'd0, PL_EL0);
		put(KIND_UNMAP,  va_at(511, 0, 0, 0), '0, 3'd0, PL_EL0);
		put(KIND_BLOCK,  '1, '0, 3'd0, PL_EL0);
		put(KIND_PAGE,   '1, '1, 3'd7, PL_SHARED);
		put(KIND_BLOCK,  va_at(0, 0, 0, 0), {16'($urandom), $urandom}, 3'd4, PL_EL0);
		put(KIND_UNMAP,  va_at(0, 0, 0, 0), '0, 3'd0, PL_EL0);

		random_run(300, 1'b1);
		drain();
		// moved pool: old table pointers mostly turn stray
		write_base({16'($urandom), $urandom});
		random_run(100, 1'b0);
		drain();
		write_base('0);
		random_run(100, 1'b0);
		drain();
		write_base('1);
		random_run(250, 1'b0);
		drain();
		repeat (50) @(posedge clk);

		if (fail_count == 0 && backlog == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
